[rtl/lse_pkg.sv]
`default_nettype none
package lse_pkg;
  localparam int unsigned FieldW = 31;
  localparam int unsigned ProdW = 2 * FieldW;

  localparam logic [1:0] VERDICT_ZERO       = 2'd0;
  localparam logic [1:0] VERDICT_RESIDUE    = 2'd1;
  localparam logic [1:0] VERDICT_NONRESIDUE = 2'd2;
  localparam logic [1:0] VERDICT_NOT_PRIME  = 2'd3;

  typedef logic [FieldW-1:0] field_t;
  typedef logic [ProdW-1:0] prod_t;

  // remainder unit request and response
  typedef struct packed {
    logic  start;
    prod_t dividend;
    field_t divisor;
  } rem_req_t;

  typedef struct packed {
    logic   done;
    field_t rem;
  } rem_rsp_t;
endpackage
`default_nettype wire

[rtl/lse_if.sv]
`default_nettype none
interface lse_in_if (input wire logic clk);
  logic                 valid;
  logic                 ready;
  logic [30:0]          residue_value;
  logic [30:0]          modulus;
  modport source (output valid, residue_value, modulus, input ready);
  modport sink (input valid, residue_value, modulus, output ready);
endinterface

interface lse_out_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [30:0] euler_power;
  modport source (output valid, verdict, euler_power, input ready);
  modport sink (input valid, verdict, euler_power, output ready);
endinterface
`default_nettype wire

[rtl/legendre_symbol_euler.sv]
`default_nettype none
// Legendre symbol of a modulo p by Euler's criterion. One beat in, one beat
// out; in_ready is low while an item is worked. All arithmetic runs through
// one shared restoring remainder unit, fed by one shared multiplier. An
// item costs one remainder for a mod p, then one per trial divisor d = 2..
// while d*d <= p (the d*d compare uses the same multiplier that forms the
// dividend), then up to two per exponent bit, so the work is far less when
// p is small or has a small factor. The result is held in an output
// register until taken, and the next item may be accepted and worked
// meanwhile.
module legendre_symbol_euler (
  input  wire logic clk,
  input  wire logic rst_n,
  lse_in_if.sink    in_ch,
  lse_out_if.source out_ch
);
  import lse_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_AMOD  = 3'd1;
  localparam logic [2:0] S_TRIAL = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SQR   = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] st_r, st_nxt, ret_r, ret_nxt;
  field_t     p_r, p_nxt, b_r, b_nxt, acc_r, acc_nxt, e_r, e_nxt;
  field_t     d_r, d_nxt;
  logic [1:0] vd_r, vd_nxt;
  field_t     pw_r, pw_nxt;
  logic       ov_r, ov_nxt;
  logic [1:0] ovd_r, ovd_nxt;
  field_t     opw_r, opw_nxt;
  rem_req_t   req;
  rem_rsp_t   rsp;
  field_t     mul_x, mul_y;
  prod_t      prod;

  lse_rem u_rem (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  // pick multiplier operands: d*d in trial, acc*b or b*b in exponent steps
  always_comb begin
    mul_x = b_r;
    mul_y = b_r;
    if (st_r == S_TRIAL) begin
      mul_x = d_r;
      mul_y = d_r;
    end else if (ret_r != S_MUL && e_r[0]) begin
      mul_x = acc_r;
    end
  end

  assign prod = prod_t'(mul_x) * prod_t'(mul_y);

  // sequencer: each arithmetic step launches the remainder unit and waits for it
  always_comb begin
    st_nxt  = st_r;  ret_nxt = ret_r;
    p_nxt   = p_r;   b_nxt   = b_r;   acc_nxt = acc_r;
    e_nxt   = e_r;   d_nxt   = d_r;
    vd_nxt  = vd_r;  pw_nxt  = pw_r;  ov_nxt  = ov_r;
    ovd_nxt = ovd_r; opw_nxt = opw_r;
    req     = '0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          p_nxt = in_ch.modulus;
          if (in_ch.modulus < field_t'(2)) begin
            vd_nxt = VERDICT_NOT_PRIME; pw_nxt = '0; st_nxt = S_OUT;
          end else begin
            req.start = 1'b1; req.dividend = prod_t'(in_ch.residue_value);
            req.divisor = in_ch.modulus;
            ret_nxt = S_AMOD; st_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: if (rsp.done) st_nxt = ret_r;
      S_AMOD: begin
        if (rsp.rem == '0) begin
          vd_nxt = VERDICT_ZERO; pw_nxt = '0; st_nxt = S_OUT;
        end else begin
          b_nxt = rsp.rem; d_nxt = field_t'(2);
          st_nxt = S_TRIAL; ret_nxt = S_IDLE;
        end
      end
      S_TRIAL: begin
        // ret_r==S_TRIAL marks a finished divide for d_r-1
        if (ret_r == S_TRIAL && rsp.rem == '0) begin
          vd_nxt = VERDICT_NOT_PRIME; pw_nxt = '0; st_nxt = S_OUT;
        end else if (prod > prod_t'(p_r)) begin
          acc_nxt = field_t'(1); e_nxt = p_r >> 1; ret_nxt = S_IDLE;
          st_nxt = S_MUL;
        end else begin
          req.start = 1'b1; req.dividend = prod_t'(p_r); req.divisor = d_r;
          d_nxt = d_r + field_t'(1); ret_nxt = S_TRIAL; st_nxt = S_WAIT;
        end
      end
      S_MUL: begin
        // returning from a multiply stores acc, then square
        if (ret_r == S_MUL) acc_nxt = rsp.rem;
        if (ret_r == S_SQR) b_nxt = rsp.rem;
        if (ret_r != S_MUL && e_r == '0) begin
          pw_nxt = acc_r;
          vd_nxt = (acc_r == field_t'(1)) ? VERDICT_RESIDUE : VERDICT_NONRESIDUE;
          st_nxt = S_OUT;
        end else if (ret_r != S_MUL && e_r[0]) begin
          req.start = 1'b1; req.dividend = prod;
          req.divisor = p_r; ret_nxt = S_MUL; st_nxt = S_WAIT;
        end else begin
          req.start = 1'b1; req.dividend = prod;
          req.divisor = p_r; e_nxt = e_r >> 1; ret_nxt = S_SQR; st_nxt = S_WAIT;
        end
      end
      S_SQR: begin
        b_nxt = rsp.rem; ret_nxt = S_SQR; st_nxt = S_MUL;
      end
      S_OUT: begin
        // load the output register once the previous beat is gone
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1; ovd_nxt = vd_r; opw_nxt = pw_r; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ret_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ret_r <= ret_nxt; ov_r <= ov_nxt;
    end
    p_r <= p_nxt; b_r <= b_nxt; acc_r <= acc_nxt; e_r <= e_nxt; d_r <= d_nxt;
    vd_r <= vd_nxt; pw_r <= pw_nxt; ovd_r <= ovd_nxt; opw_r <= opw_nxt;
  end

  assign in_ch.ready        = (st_r == S_IDLE);
  assign out_ch.valid       = ov_r;
  assign out_ch.verdict     = ovd_r;
  assign out_ch.euler_power = opw_r;

  a_power_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (ovd_r == VERDICT_ZERO || ovd_r == VERDICT_NOT_PRIME) |-> opw_r == '0)
    else $error("power not cleared");
  a_residue_one: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ovd_r == VERDICT_RESIDUE |-> opw_r == field_t'(1)) else $error("bad residue");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> ov_r && $stable(ovd_r) && $stable(opw_r))
    else $error("result lost");
endmodule
`default_nettype wire

[rtl/lse_rem.sv]
`default_nettype none
// Restoring remainder: one quotient bit per cycle.
module lse_rem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lse_pkg::rem_req_t req,
  output lse_pkg::rem_rsp_t      rsp
);
  import lse_pkg::*;

  localparam int unsigned CntW = $clog2(ProdW + 1);

  logic              busy_r, busy_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  prod_t             num_r, num_nxt;
  logic [FieldW:0]   part_r, part_nxt;
  field_t            div_r;
  logic              done_r, done_nxt;
  logic [FieldW+1:0] shifted;
  logic [FieldW+1:0] diff;

  // shift in one dividend bit and try a subtract
  always_comb begin
    shifted  = {part_r, num_r[ProdW-1]};
    diff     = shifted - {2'b00, div_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    part_nxt = part_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(ProdW);
      num_nxt  = req.dividend;
      part_nxt = '0;
    end else if (busy_r) begin
      num_nxt  = {num_r[ProdW-2:0], 1'b0};
      part_nxt = diff[FieldW+1] ? shifted[FieldW:0] : diff[FieldW:0];
      cnt_nxt  = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r  <= num_nxt;
    part_r <= part_nxt;
    if (req.start) div_r <= req.divisor;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = part_r[FieldW-1:0];

  // done pulses exactly once after a run
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r != CntW'(1) |=> busy_r || req.start) else $error("busy dropped");
  a_rem_lt_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> part_r < {1'b0, div_r}) else $error("remainder too large");
endmodule
`default_nettype wire
